[sv/rbd_pkg.sv]
// Shared constants, codes and types for the ring buffer deque.
package rbd_pkg;

  localparam int MAX_DEPTH = 64;
  localparam int ELEM_W    = 32;
  localparam int ADDR_W    = $clog2(MAX_DEPTH);
  localparam int CAP_W     = 7;
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;

  typedef logic [FUNC_W-1:0] func_t;
  typedef logic [STAT_W-1:0] stat_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CAP_W-1:0]  cnt_t;
  typedef logic [ELEM_W-1:0] elem_t;

  localparam func_t OP_PUSH_BACK  = 2'd0;
  localparam func_t OP_PUSH_FRONT = 2'd1;
  localparam func_t OP_POP_FRONT  = 2'd2;
  localparam func_t OP_POP_BACK   = 2'd3;

  localparam stat_t ST_OK         = 2'd0;
  localparam stat_t ST_POP_EMPTY  = 2'd1;
  localparam stat_t ST_PUSH_FULL  = 2'd2;

endpackage

[sv/rbd_if.sv]
// Valid/ready channel interfaces for the deque operation and result streams.
interface rbd_in_if;
  logic              valid;
  logic              ready;
  rbd_pkg::func_t    func;
  rbd_pkg::elem_t    push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink   (input valid, input func, input push_value, output ready);
endinterface

interface rbd_out_if;
  logic              valid;
  logic              ready;
  rbd_pkg::elem_t    pop_value;
  rbd_pkg::stat_t    status;
  rbd_pkg::cnt_t     count;
  logic              is_empty;
  logic              is_full;

  modport source (output valid, output pop_value, output status, output count,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input pop_value, input status, input count,
                  input is_empty, input is_full, output ready);
endinterface

[sv/ring_buffer_deque.sv]
// Ring buffer deque top level: pointer/count control around the slot RAM.
// Results: a push or a refused operation loads the output register on transfer;
//   a successful pop reads its slot into the RAM output register, then S_READ loads the result.
// Throughput: one push per cycle when output is free; a pop stalls input for its slot RAM read.
// Reset (rst, synchronous): head, tail and count go to 0, capacity to 64, output empties.
// The slot RAM is not cleared; a pop only ever reads slots written by an earlier push.
module ring_buffer_deque (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  rbd_pkg::cnt_t  cfg_data,
  rbd_in_if.sink         in_ch,
  rbd_out_if.source      out_ch
);

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t          state;
  rbd_pkg::cnt_t   cap_reg;      // raw capacity register
  rbd_pkg::cnt_t   cap_use;      // capacity clamped to 1..MAX_DEPTH
  rbd_pkg::addr_t  head;
  rbd_pkg::addr_t  tail;
  rbd_pkg::cnt_t   held_count;

  rbd_pkg::addr_t  head_next;
  rbd_pkg::addr_t  tail_next;
  rbd_pkg::cnt_t   count_next;
  rbd_pkg::addr_t  head_inc, head_dec, tail_inc, tail_dec;

  logic            in_xfer;
  logic            is_push;
  logic            push_ok;
  logic            pop_ok;
  logic            out_free;
  rbd_pkg::stat_t  stat_next;

  // RAM port signals
  logic            ram_we;
  rbd_pkg::addr_t  ram_waddr;
  logic            ram_re;
  rbd_pkg::addr_t  ram_raddr;
  rbd_pkg::elem_t  ram_rdata;

  // Result fields of a pop held while the RAM read completes
  rbd_pkg::cnt_t   pend_count;
  logic            pend_full;

  // Output register
  logic            out_valid;
  rbd_pkg::elem_t  out_pop_value;
  rbd_pkg::stat_t  out_status;
  rbd_pkg::cnt_t   out_count;
  logic            out_empty;
  logic            out_full;

  // Clamp the capacity: zero acts as one, anything above the store depth as the depth.
  always_comb begin
    priority if (cap_reg == '0) begin
      cap_use = rbd_pkg::CAP_W'(1);
    end else if (cap_reg > rbd_pkg::CAP_W'(rbd_pkg::MAX_DEPTH)) begin
      cap_use = rbd_pkg::CAP_W'(rbd_pkg::MAX_DEPTH);
    end else begin
      cap_use = cap_reg;
    end
  end

  // Wrapping neighbors of both pointers within the capacity in use.
  always_comb begin
    head_inc = (rbd_pkg::CAP_W'(head) + 1'b1 >= cap_use) ? '0 : head + 1'b1;
    tail_inc = (rbd_pkg::CAP_W'(tail) + 1'b1 >= cap_use) ? '0 : tail + 1'b1;
    head_dec = (head == '0 || rbd_pkg::CAP_W'(head) >= cap_use)
               ? rbd_pkg::ADDR_W'(cap_use - 1'b1) : head - 1'b1;
    tail_dec = (tail == '0 || rbd_pkg::CAP_W'(tail) >= cap_use)
               ? rbd_pkg::ADDR_W'(cap_use - 1'b1) : tail - 1'b1;
  end

  // The output register is free when empty or being drained this cycle.
  assign out_free     = !out_valid || out_ch.ready;
  assign in_ch.ready  = (state == S_IDLE) && out_free;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign is_push      = (in_ch.func == rbd_pkg::OP_PUSH_BACK) ||
                        (in_ch.func == rbd_pkg::OP_PUSH_FRONT);
  assign push_ok      = is_push && (held_count < cap_use);
  assign pop_ok       = !is_push && (held_count != '0);

  // Decide the next pointers, count and RAM access for the offered operation.
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = held_count;
    ram_waddr  = '0;
    ram_raddr  = head;
    stat_next  = rbd_pkg::ST_OK;
    unique case (in_ch.func)
      rbd_pkg::OP_PUSH_BACK, rbd_pkg::OP_PUSH_FRONT: begin
        if (!push_ok) begin
          stat_next = rbd_pkg::ST_PUSH_FULL;
        end else begin
          count_next = held_count + 1'b1;
          priority if (held_count == '0) begin
            // First element lands in slot 0 with both pointers on it.
            head_next = '0;
            tail_next = '0;
            ram_waddr = '0;
          end else if (in_ch.func == rbd_pkg::OP_PUSH_BACK) begin
            tail_next = tail_inc;
            ram_waddr = tail_inc;
          end else begin
            head_next = head_dec;
            ram_waddr = head_dec;
          end
        end
      end
      rbd_pkg::OP_POP_FRONT, rbd_pkg::OP_POP_BACK: begin
        if (!pop_ok) begin
          stat_next = rbd_pkg::ST_POP_EMPTY;
        end else begin
          count_next = held_count - 1'b1;
          if (in_ch.func == rbd_pkg::OP_POP_FRONT) begin
            ram_raddr = head;
            head_next = head_inc;
          end else begin
            ram_raddr = tail;
            tail_next = tail_dec;
          end
          // Last element gone: park both pointers at slot 0.
          if (held_count == rbd_pkg::CAP_W'(1)) begin
            head_next = '0;
            tail_next = '0;
          end
        end
      end
      default: begin
        stat_next = rbd_pkg::ST_OK;
      end
    endcase
  end

  assign ram_we = in_xfer && push_ok;
  assign ram_re = in_xfer && pop_ok;

  rbd_ram #(
    .DEPTH (rbd_pkg::MAX_DEPTH),
    .WIDTH (rbd_pkg::ELEM_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.push_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Control state, pointers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cap_reg    <= rbd_pkg::CAP_W'(rbd_pkg::MAX_DEPTH);
      head       <= '0;
      tail       <= '0;
      held_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // A capacity write empties the queue; otherwise advance on a transfer.
      if (cfg_we) begin
        cap_reg    <= cfg_data;
        head       <= '0;
        tail       <= '0;
        held_count <= '0;
      end else if (in_xfer) begin
        head       <= head_next;
        tail       <= tail_next;
        held_count <= count_next;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer && pop_ok) begin
            // Hold the result fields until the slot data returns from RAM.
            pend_count <= count_next;
            pend_full  <= (count_next == cap_use);
            state      <= S_READ;
            if (out_ch.ready) begin
              out_valid <= 1'b0;
            end
          end else if (in_xfer) begin
            out_valid     <= 1'b1;
            out_pop_value <= '0;
            out_status    <= stat_next;
            out_count     <= count_next;
            out_empty     <= (count_next == '0);
            out_full      <= (count_next == cap_use);
          end else if (out_ch.ready) begin
            // Drop the result once the sink takes it.
            out_valid <= 1'b0;
          end
        end
        S_READ: begin
          // Read data stays in the RAM output register until the result can load.
          if (out_free) begin
            out_valid     <= 1'b1;
            out_pop_value <= ram_rdata;
            out_status    <= rbd_pkg::ST_OK;
            out_count     <= pend_count;
            out_empty     <= (pend_count == '0);
            out_full      <= pend_full;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.pop_value = out_pop_value;
  assign out_ch.status    = out_status;
  assign out_ch.count     = out_count;
  assign out_ch.is_empty  = out_empty;
  assign out_ch.is_full   = out_full;

`ifndef SYNTHESIS
  a_count_le_cap: assert property (@(posedge clk) disable iff (rst)
    held_count <= cap_use)
    else $error("held count exceeds capacity in use");

  a_single_elem_ptrs: assert property (@(posedge clk) disable iff (rst)
    held_count <= rbd_pkg::CAP_W'(1) |-> head == tail)
    else $error("head and tail differ with at most one element held");

  a_pop_reads: assert property (@(posedge clk) disable iff (rst)
    in_xfer && pop_ok |=> state == S_READ)
    else $error("successful pop did not wait for slot read");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_empty == (out_count == '0))
    else $error("empty flag disagrees with result count");

  a_no_xfer_in_read: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !in_ch.ready)
    else $error("input taken while a pop read is outstanding");
`endif

endmodule

[sv/rbd_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
module rbd_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
